@@ rtl/core/jfhs_pkg.sv @@
// Shared types, codes and constants of the JPEG frame header scanner.
package jfhs_pkg;

	// Position within the marker segment walk.
	typedef enum logic [3:0] {
		PH_PREFIX,
		PH_TYPE,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_SKIP,
		PH_PREC,
		PH_H_HI,
		PH_H_LO,
		PH_W_HI,
		PH_W_LO,
		PH_COMP,
		PH_FOUND,
		PH_FAILED
	} phase_t;

	// Parse status codes as seen on the result channel.
	localparam logic [1:0] STATUS_SCANNING = 2'd0;
	localparam logic [1:0] STATUS_FOUND    = 2'd1;
	localparam logic [1:0] STATUS_FAILED   = 2'd2;

	// Marker bytes.
	localparam logic [7:0] MARKER_PREFIX = 8'hFF;
	localparam logic [7:0] MARKER_SOF0   = 8'hC0;
	localparam logic [7:0] MARKER_SOF1   = 8'hC1;
	localparam logic [7:0] MARKER_SOF2   = 8'hC2;
	localparam logic [7:0] MARKER_SOF9   = 8'hC9;
	localparam logic [7:0] MARKER_SOF10  = 8'hCA;

	// Segment length of the length field alone; only longer segments carry payload bytes.
	localparam logic [15:0] LENGTH_FIELD_BYTES = 16'd2;

	typedef struct packed {
		phase_t      phase;
		logic        frame_marker_seen;
		logic [7:0]  length_high;
		logic [15:0] skip_remaining;
		logic [15:0] height;
		logic [15:0] width;
		logic [7:0]  components;
	} scan_state_t;

	typedef struct packed {
		logic [1:0]  parse_status;
		logic        header_valid;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [7:0]  channel_count;
	} scan_result_t;

	localparam scan_state_t SCAN_STATE_RESET = '{
		phase:             PH_PREFIX,
		frame_marker_seen: 1'b0,
		length_high:       8'd0,
		skip_remaining:    16'd0,
		height:            16'd0,
		width:             16'd0,
		components:        8'd0
	};

	function automatic logic is_frame_type(input logic [7:0] t);
		return (t == MARKER_SOF0) || (t == MARKER_SOF1) || (t == MARKER_SOF2) ||
			(t == MARKER_SOF9) || (t == MARKER_SOF10);
	endfunction

endpackage

@@ rtl/core/jfhs_step.sv @@
// Next-state and result logic of the scanner for one stream byte.
module jfhs_step
	import jfhs_pkg::*;
(
	input  scan_state_t  cur,
	input  logic [7:0]   data_byte,
	input  logic         restart,
	output scan_state_t  nxt,
	output scan_result_t res
);

	scan_state_t base;
	logic [15:0] seg_len;
	logic [15:0] skip_dec;
	logic        all_nonzero;

	always_comb begin
		// A restart clears the state before the byte is examined.
		base = restart ? SCAN_STATE_RESET : cur;
		seg_len = {base.length_high, data_byte};
		skip_dec = base.skip_remaining - 16'd1;
		nxt = base;
		case (base.phase)
			PH_PREFIX: begin
				nxt.phase = (data_byte == MARKER_PREFIX) ? PH_TYPE : PH_FAILED;
			end
			PH_TYPE: begin
				nxt.frame_marker_seen = is_frame_type(data_byte);
				nxt.phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				if (data_byte == MARKER_PREFIX) begin
					// Missing length: the byte doubles as the next prefix or,
					// in a frame segment, as the precision byte.
					nxt.phase = base.frame_marker_seen ? PH_H_HI : PH_TYPE;
				end else begin
					nxt.length_high = data_byte;
					nxt.phase = PH_LEN_LO;
				end
			end
			PH_LEN_LO: begin
				if (base.frame_marker_seen) begin
					nxt.phase = PH_PREC;
				end else if (seg_len > LENGTH_FIELD_BYTES) begin
					nxt.skip_remaining = seg_len - LENGTH_FIELD_BYTES;
					nxt.phase = PH_SKIP;
				end else begin
					nxt.phase = PH_PREFIX;
				end
			end
			PH_SKIP: begin
				nxt.skip_remaining = skip_dec;
				if (skip_dec == 16'd0) begin
					nxt.phase = PH_PREFIX;
				end
			end
			PH_PREC: begin
				nxt.phase = PH_H_HI;
			end
			PH_H_HI: begin
				nxt.height = {data_byte, 8'd0};
				nxt.phase = PH_H_LO;
			end
			PH_H_LO: begin
				nxt.height = {base.height[15:8], data_byte};
				nxt.phase = PH_W_HI;
			end
			PH_W_HI: begin
				nxt.width = {data_byte, 8'd0};
				nxt.phase = PH_W_LO;
			end
			PH_W_LO: begin
				nxt.width = {base.width[15:8], data_byte};
				nxt.phase = PH_COMP;
			end
			PH_COMP: begin
				nxt.components = data_byte;
				nxt.phase = PH_FOUND;
			end
			PH_FOUND, PH_FAILED: begin
				nxt.phase = base.phase;
			end
			default: begin
				nxt.phase = PH_FAILED;
			end
		endcase

		all_nonzero = (nxt.width != 16'd0) && (nxt.height != 16'd0) &&
			(nxt.components != 8'd0);
		res.header_valid = (nxt.phase == PH_FOUND) && all_nonzero;
		if (nxt.phase == PH_FOUND) begin
			res.parse_status = STATUS_FOUND;
		end else if (nxt.phase == PH_FAILED) begin
			res.parse_status = STATUS_FAILED;
		end else begin
			res.parse_status = STATUS_SCANNING;
		end
		res.image_width   = res.header_valid ? nxt.width : 16'd0;
		res.image_height  = res.header_valid ? nxt.height : 16'd0;
		res.channel_count = res.header_valid ? nxt.components : 8'd0;
	end

endmodule

@@ rtl/core/jpeg_frame_header_scanner_top.sv @@
// Top level of the JPEG frame header scanner: input register, scan state and result register.
//
// The block takes a JPEG byte stream on the byte channel, one word per byte,
// with restart set on the first byte of each new image. For every accepted
// word it returns exactly one word on the result channel: the parse status
// after that byte, and the frame width, height and component count once a
// start-of-frame segment has been read with all three values non-zero.
//
// Both channels use valid and stall. A byte word is captured in an input
// register at the edge it is accepted; once the result register is free or
// being emptied, the scan state is advanced and the result word lands in the
// output register, from where the receiver takes it.
// One byte is taken every cycle while the result side keeps up; the whole
// decision for a byte is one pass through the step logic between those two
// registers.
//
// When the receiver stalls, the result register holds its word and the input
// register still takes one more byte, after which the byte channel stalls
// until the result is taken. Reset returns the scanner to expecting a marker
// prefix and empties both registers; no word is pending afterwards.
module jpeg_frame_header_scanner_top
	import jfhs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  parse_status,
	output logic        header_valid,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic [7:0]  channel_count
);

	logic         valid_s1;
	logic [7:0]   data_s1;
	logic         restart_s1;
	scan_state_t  state_q;
	scan_state_t  state_nxt;
	scan_result_t step_res;
	scan_result_t result_q;
	logic         result_valid_q;
	logic         advance;

	// The held byte moves on whenever the result register is free or being emptied.
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign byte_stall = valid_s1 && result_valid_q && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			data_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

	jfhs_step u_step (
		.cur       (state_q),
		.data_byte (data_s1),
		.restart   (restart_s1),
		.nxt       (state_nxt),
		.res       (step_res)
	);

	// The scan state advances only when its result has a place to go.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SCAN_STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= step_res;
		end
	end

	assign result_valid  = result_valid_q;
	assign parse_status  = result_q.parse_status;
	assign header_valid  = result_q.header_valid;
	assign image_width   = result_q.image_width;
	assign image_height  = result_q.image_height;
	assign channel_count = result_q.channel_count;

endmodule

@@ rtl/core/jfhs_checker.sv @@
// Port-level checks of the scanner's result channel, bound to the top level.
module jfhs_checker
	import jfhs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  parse_status,
	input logic        header_valid,
	input logic [15:0] image_width,
	input logic [15:0] image_height,
	input logic [7:0]  channel_count
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(parse_status) && $stable(header_valid) &&
			$stable(image_width) && $stable(image_height) && $stable(channel_count))
		else $error("stalled result word changed");

	a_valid_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && header_valid |-> parse_status == STATUS_FOUND &&
			image_width != 16'd0 && image_height != 16'd0 && channel_count != 8'd0)
		else $error("header reported without a complete frame header");

	a_values_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !header_valid |->
			image_width == 16'd0 && image_height == 16'd0 && channel_count == 8'd0)
		else $error("frame values shown without a valid header");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> parse_status == STATUS_SCANNING ||
			parse_status == STATUS_FOUND || parse_status == STATUS_FAILED)
		else $error("undefined parse status");

endmodule

bind jpeg_frame_header_scanner_top jfhs_checker u_jfhs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.parse_status  (parse_status),
	.header_valid  (header_valid),
	.image_width   (image_width),
	.image_height  (image_height),
	.channel_count (channel_count)
);

@@ tb/tb_jpeg_frame_header_scanner_top.sv @@
`timescale 1ns / 1ps
// Testbench for the JPEG frame header scanner: queued byte driver, result monitor, scan predictor.
module tb_jpeg_frame_header_scanner_top;
	import jfhs_pkg::*;

	// One word on the byte channel.
	typedef struct packed {
		logic [7:0] value;
		logic       restart;
	} byte_word_t;

	// The random part stops once roughly this many bytes are queued.
	localparam int TARGET_BYTES = 390;
	// Neither side idles while fewer than this many bytes are still to be sent.
	localparam int CALM_TAIL = 60;
	// Edges waited after the last expected result before the run ends.
	localparam int DRAIN_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        restart = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  parse_status;
	logic        header_valid;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic [7:0]  channel_count;

	jpeg_frame_header_scanner_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.restart      (restart),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.parse_status (parse_status),
		.header_valid (header_valid),
		.image_width  (image_width),
		.image_height (image_height),
		.channel_count(channel_count)
	);

	// A 12 ns clock, low first.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Bytes still to be offered, and the result words that accepted bytes will produce.
	byte_word_t   pending_bytes [$];
	scan_result_t expected_results [$];

	// The five start-of-frame types that carry a frame header.
	logic [7:0] sof_kinds [5] = '{MARKER_SOF0, MARKER_SOF1, MARKER_SOF2, MARKER_SOF9,
		MARKER_SOF10};

	// Shadow copy of the scanner state, kept by the predictor.
	phase_t      sc_phase = PH_PREFIX;
	logic        sc_frame = 1'b0;
	logic [7:0]  sc_len_hi = 8'd0;
	logic [15:0] sc_skip = 16'd0;
	logic [15:0] sc_height = 16'd0;
	logic [15:0] sc_width = 16'd0;
	logic [7:0]  sc_comps = 8'd0;

	// Handshake and bookkeeping shared between the driver and the monitor.
	bit byte_taken = 1'b0;
	bit quiet = 1'b0;
	int byte_gap = 0;
	int stall_left = 0;
	int calm_left = 0;
	int mismatch_count = 0;
	int words_checked = 0;
	int headers_found = 0;
	int failed_words = 0;
	int image_count = 0;
	int bytes_sent = 0;

	// Advances the shadow scanner by one byte and returns the result word that follows.
	function automatic scan_result_t scan_byte(input logic [7:0] b, input logic fresh);
		scan_result_t r;
		logic [15:0]  seg_len;
		// A restart clears everything before the byte itself is looked at.
		if (fresh) begin
			sc_phase  = PH_PREFIX;
			sc_frame  = 1'b0;
			sc_len_hi = 8'd0;
			sc_skip   = 16'd0;
			sc_height = 16'd0;
			sc_width  = 16'd0;
			sc_comps  = 8'd0;
		end
		case (sc_phase)
			PH_PREFIX: sc_phase = (b == MARKER_PREFIX) ? PH_TYPE : PH_FAILED;
			PH_TYPE: begin
				sc_frame = b inside {MARKER_SOF0, MARKER_SOF1, MARKER_SOF2, MARKER_SOF9,
					MARKER_SOF10};
				sc_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				// A prefix byte here means the length is missing. In a frame segment it stands in
				// for the precision byte; elsewhere it opens the next marker.
				if (b == MARKER_PREFIX) begin
					sc_phase = sc_frame ? PH_H_HI : PH_TYPE;
				end else begin
					sc_len_hi = b;
					sc_phase  = PH_LEN_LO;
				end
			end
			PH_LEN_LO: begin
				seg_len = {sc_len_hi, b};
				if (sc_frame) begin
					sc_phase = PH_PREC;
				end else if (seg_len > LENGTH_FIELD_BYTES) begin
					sc_skip  = seg_len - LENGTH_FIELD_BYTES;
					sc_phase = PH_SKIP;
				end else begin
					sc_phase = PH_PREFIX;
				end
			end
			PH_SKIP: begin
				sc_skip = sc_skip - 16'd1;
				if (sc_skip == 16'd0)
					sc_phase = PH_PREFIX;
			end
			PH_PREC: sc_phase = PH_H_HI;
			PH_H_HI: begin
				sc_height = {b, 8'd0};
				sc_phase  = PH_H_LO;
			end
			PH_H_LO: begin
				sc_height = sc_height | {8'd0, b};
				sc_phase  = PH_W_HI;
			end
			PH_W_HI: begin
				sc_width = {b, 8'd0};
				sc_phase = PH_W_LO;
			end
			PH_W_LO: begin
				sc_width = sc_width | {8'd0, b};
				sc_phase = PH_COMP;
			end
			PH_COMP: begin
				sc_comps = b;
				sc_phase = PH_FOUND;
			end
			PH_FOUND, PH_FAILED: ;
			default: sc_phase = PH_FAILED;
		endcase
		r = '0;
		r.parse_status = STATUS_SCANNING;
		if (sc_phase == PH_FOUND) begin
			r.parse_status = STATUS_FOUND;
			r.header_valid = (sc_width != 16'd0) && (sc_height != 16'd0) && (sc_comps != 8'd0);
			if (r.header_valid) begin
				r.image_width   = sc_width;
				r.image_height  = sc_height;
				r.channel_count = sc_comps;
			end
		end else if (sc_phase == PH_FAILED) begin
			r.parse_status = STATUS_FAILED;
		end
		return r;
	endfunction

	task automatic put(input logic [7:0] b, input logic fresh);
		byte_word_t w;
		w.value   = b;
		w.restart = fresh;
		pending_bytes.push_back(w);
		if (fresh)
			image_count++;
	endtask

	// Driver: every input changes on the falling edge only. A byte that has been
	// offered is held until the monitor has seen it accepted.
	always @(negedge clk) begin : drive
		byte_word_t w;
		if (arst_n) begin
			quiet = (calm_left > 0) || (pending_bytes.size() < CALM_TAIL);
			// No idle burst carries on into a quiet stretch.
			if (quiet) begin
				byte_gap   = 0;
				stall_left = 0;
			end
			if (!byte_valid || byte_taken) begin
				if (byte_gap > 0) begin
					byte_valid <= 1'b0;
					byte_gap--;
				end else if (pending_bytes.size() == 0) begin
					byte_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 5) == 0) begin
					// The idle cycle driven now is the first of the burst.
					byte_valid <= 1'b0;
					byte_gap = $urandom_range(1, 11) - 1;
				end else begin
					w = pending_bytes.pop_front();
					byte_valid <= 1'b1;
					data_byte  <= w.value;
					restart    <= w.restart;
					bytes_sent++;
					// Now and then a stretch of words goes through with no idling at all.
					if (calm_left > 0)
						calm_left--;
					else if ($urandom_range(0, 39) == 0)
						calm_left = $urandom_range(15, 40);
				end
			end
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				result_stall <= 1'b1;
				stall_left = $urandom_range(1, 11) - 1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Monitor: both handshakes are sampled on the rising edge. The result word is
	// checked before the byte of the same edge is predicted; that byte's result passes
	// through the input register and the result register before it can show up.
	always @(posedge clk) begin : observe
		scan_result_t want;
		if (arst_n) begin
			byte_taken = byte_valid && !byte_stall;
			if (result_valid && !result_stall) begin
				words_checked++;
				if (parse_status == STATUS_FAILED)
					failed_words++;
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected: status %0d", parse_status);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (want.header_valid)
						headers_found++;
					if (parse_status !== want.parse_status) begin
						$error("parse_status: expected %0d, got %0d", want.parse_status,
							parse_status);
						mismatch_count++;
					end
					if (header_valid !== want.header_valid) begin
						$error("header_valid: expected %0d, got %0d", want.header_valid,
							header_valid);
						mismatch_count++;
					end
					if (image_width !== want.image_width) begin
						$error("image_width: expected %0d, got %0d", want.image_width,
							image_width);
						mismatch_count++;
					end
					if (image_height !== want.image_height) begin
						$error("image_height: expected %0d, got %0d", want.image_height,
							image_height);
						mismatch_count++;
					end
					if (channel_count !== want.channel_count) begin
						$error("channel_count: expected %0d, got %0d", want.channel_count,
							channel_count);
						mismatch_count++;
					end
				end
			end
			if (byte_taken)
				expected_results.push_back(scan_byte(data_byte, restart));
		end else begin
			byte_taken = 1'b0;
		end
	end

	// Stimulus, reset and the end of the run.
	initial begin : stimulus
		logic [7:0]  image [$];
		logic [7:0]  seg_type;
		logic [15:0] dim_h;
		logic [15:0] dim_w;
		logic [7:0]  comps;
		bit          prefix_owed;
		int          seg_len;
		int          cut;

		// Directed part. A frame segment whose length byte is a prefix: that byte
		// counts as the precision, and height, width and count are all at their top.
		put(MARKER_PREFIX, 1'b1);
		put(MARKER_SOF0, 1'b0);
		repeat (6) put(MARKER_PREFIX, 1'b0);
		// A stream that does not open with a prefix fails; the next byte is ignored.
		put(8'h00, 1'b1);
		put(MARKER_PREFIX, 1'b0);
		// Start of image has no length, so its following prefix opens the next marker.
		// The frame then reports a zero height, so nothing is valid; the bytes
		// after the header are ignored.
		put(MARKER_PREFIX, 1'b1);
		put(8'hD8, 1'b0);
		put(MARKER_PREFIX, 1'b0);
		put(MARKER_SOF2, 1'b0);
		put(8'h00, 1'b0);
		put(8'h11, 1'b0);
		put(8'h08, 1'b0);
		put(8'h00, 1'b0);
		put(8'h00, 1'b0);
		put(8'h01, 1'b0);
		put(8'h00, 1'b0);
		put(8'h03, 1'b0);
		put(8'h5A, 1'b0);

		// Random part: mostly well-formed images with random segments ahead of a
		// frame header, the rest cut short, with a broken prefix, or plain noise.
		while (pending_bytes.size() < TARGET_BYTES) begin
			image.delete();
			prefix_owed = 1'b1;
			repeat ($urandom_range(0, 3)) begin
				if (prefix_owed)
					image.push_back(MARKER_PREFIX);
				do
					seg_type = 8'($urandom_range(0, 255));
				while (seg_type inside {MARKER_SOF0, MARKER_SOF1, MARKER_SOF2, MARKER_SOF9,
					MARKER_SOF10});
				image.push_back(seg_type);
				case ($urandom_range(0, 5))
					0: begin
						// No length: this prefix byte opens the next segment.
						image.push_back(MARKER_PREFIX);
						prefix_owed = 1'b0;
					end
					1: begin
						// Length too short to carry anything.
						image.push_back(8'h00);
						image.push_back(8'($urandom_range(0, 2)));
						prefix_owed = 1'b1;
					end
					default: begin
						seg_len = $urandom_range(3, 14);
						image.push_back(8'h00);
						image.push_back(8'(seg_len));
						repeat (seg_len - 2) image.push_back(8'($urandom_range(0, 255)));
						prefix_owed = 1'b1;
					end
				endcase
			end
			if (prefix_owed)
				image.push_back(MARKER_PREFIX);
			image.push_back(sof_kinds[3'($urandom_range(0, 4))]);
			if ($urandom_range(0, 3) == 0) begin
				image.push_back(MARKER_PREFIX);
			end else begin
				image.push_back(8'($urandom_range(0, 254)));
				image.push_back(8'($urandom_range(0, 255)));
				image.push_back(8'd8);
			end
			dim_h = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
			dim_w = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
			comps = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
			image.push_back(dim_h[15:8]);
			image.push_back(dim_h[7:0]);
			image.push_back(dim_w[15:8]);
			image.push_back(dim_w[7:0]);
			image.push_back(comps);
			repeat ($urandom_range(0, 3)) image.push_back(8'($urandom_range(0, 255)));
			case ($urandom_range(0, 9))
				0: begin
					cut = $urandom_range(1, image.size() - 1);
					while (image.size() > cut)
						void'(image.pop_back());
				end
				1: image[0] = 8'($urandom_range(0, 254));
				2: begin
					image.delete();
					repeat ($urandom_range(1, 8)) image.push_back(8'($urandom_range(0, 255)));
				end
				default: ;
			endcase
			foreach (image[i])
				put(image[i], i == 0);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || byte_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes over %0d images; %0d result words checked.", bytes_sent,
			image_count, words_checked);
		$display("%0d words carried a valid frame header, %0d reported a missing prefix.",
			headers_found, failed_words);
		if (mismatch_count == 0)
			$display("jpeg_frame_header_scanner_top test passed");
		else
			$display("jpeg_frame_header_scanner_top test failed");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("Timed out with %0d bytes and %0d results outstanding.",
			pending_bytes.size(), expected_results.size());
		$display("jpeg_frame_header_scanner_top test failed");
		$finish;
	end

endmodule
